FILE: src/decimal_radix_sorter_defines.svh
// Assertion macros used by the sorter's top-level RTL file.
`ifndef DECIMAL_RADIX_SORTER_DEFINES_SVH
`define DECIMAL_RADIX_SORTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define DRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/drs_pkg.sv
// Package with constants, types and helpers shared by the sorter modules.
package drs_pkg;

    localparam int DRS_MAX_ITEMS  = 64;
    localparam int DRS_VALUE_BITS = 31;
    localparam int DRS_RADIX      = 10;
    localparam int DRS_TDATA_W    = 32;

    // Decimal digits needed for a value of the given width (log10(2) ~ 1233/4096).
    function automatic int bcd_digits(input int bits);
        return (bits * 1233) / 4096 + 1;
    endfunction

    // Status of the binary-to-BCD converter.
    typedef struct packed {
        logic busy;
        logic done;
    } conv_stat_t;

endpackage

FILE: src/decimal_radix_sorter.sv
// Decimal radix sorter: loads a batch of words (tlast marks the final one), sorts them in
// ascending order with a stable least-significant-digit base-10 radix sort, and streams the
// sorted batch out with tlast on the final word. Each loaded word passes through a shared
// shift-and-adjust BCD converter, so the input takes a new word only once the converter is
// through with the last one, and s_tready stays low meanwhile. Words beyond MAX_ITEMS in one
// batch are dropped; a tlast word still starts the sort. The sort runs one pass per decimal
// digit of the batch maximum (none when the maximum is zero); each pass has a bin clear, a
// histogram sweep, a ten-step prefix sum and a scatter sweep, all through one read port
// of two ping-pong RAMs. Output then reads, registers and holds one word at a time, moving
// on to the next word once m_tready is high.
// s_tready is low from the tlast word until the final output word has been taken.
`include "decimal_radix_sorter_defines.svh"

module decimal_radix_sorter #(
    parameter int MAX_ITEMS  = drs_pkg::DRS_MAX_ITEMS,
    parameter int VALUE_BITS = drs_pkg::DRS_VALUE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [drs_pkg::DRS_TDATA_W-1:0] s_tdata,   // [30:0] value, [31] zero
    input  logic                            s_tlast,   // last_item
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [drs_pkg::DRS_TDATA_W-1:0] m_tdata,   // [30:0] sorted_value, [31] zero
    output logic                            m_tlast    // last_result
);
    import drs_pkg::*;

    localparam int DIGITS = bcd_digits(VALUE_BITS);
    localparam int BCD_W  = 4 * DIGITS;
    localparam int ENT_W  = VALUE_BITS + BCD_W;      // stored word: {bcd, value}
    localparam int AW     = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int MD_W   = $clog2(DIGITS + 1);
    localparam int BIN_AW = $clog2(DRS_RADIX);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CONV, ST_START, ST_CLR, ST_HIST, ST_PSUM, ST_SCAT,
        ST_OUT_RD, ST_OUT_WAIT, ST_OUT_HOLD
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;     // words stored in this batch
    logic [CNT_W-1:0]      idx_reg, idx_next;         // sweep position
    logic [MD_W-1:0]       maxdig_reg, maxdig_next;   // digit count of the batch maximum
    logic [MD_W-1:0]       pass_reg, pass_next;       // digit under sort
    logic [BIN_AW-1:0]     bin_k_reg, bin_k_next;     // prefix-sum step
    logic [CNT_W-1:0]      acc_reg, acc_next;
    logic [CNT_W-1:0]      bins_reg [DRS_RADIX];
    logic [CNT_W-1:0]      bins_next [DRS_RADIX];
    logic                  pend_reg, pend_next;       // a RAM read is in flight
    logic                  src_sel_reg, src_sel_next; // RAM holding the current order
    logic                  last_reg, last_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  tvalid_reg, tvalid_next;

    logic                  conv_start;
    logic [BCD_W-1:0]      conv_bcd;
    conv_stat_t            conv_stat;
    logic [MD_W-1:0]       conv_ndig;

    logic                  ram_we, wr_to_src;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [ENT_W-1:0]      ram_wdata, rd0, rd1, rd_entry;
    logic [BIN_AW-1:0]     rd_digit;
    logic [CNT_W-1:0]      psum;

    drs_bcd_conv #(.VALUE_BITS(VALUE_BITS)) u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .value   (s_tdata[VALUE_BITS-1:0]),
        .bcd     (conv_bcd),
        .stat    (conv_stat)
    );

    // Ping-pong stores: each pass reads one and scatters into the other.
    drs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ITEMS)) u_ram0 (
        .aclk  (aclk),
        .we    (ram_we && ((wr_to_src ? src_sel_reg : !src_sel_reg) == 1'b0)),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd0)
    );

    drs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ITEMS)) u_ram1 (
        .aclk  (aclk),
        .we    (ram_we && ((wr_to_src ? src_sel_reg : !src_sel_reg) == 1'b1)),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd1)
    );

    assign rd_entry = src_sel_reg ? rd1 : rd0;
    // Digit of the returning word for the current pass.
    assign rd_digit = BIN_AW'(rd_entry[VALUE_BITS + 4*pass_reg +: 4]);
    assign psum     = acc_reg + bins_reg[bin_k_reg];

    // Digit count of the converted word: position of its highest nonzero digit.
    always_comb begin
        conv_ndig = '0;
        for (int j = 0; j < DIGITS; j++) begin
            if (conv_bcd[4*j +: 4] != 4'd0) begin
                conv_ndig = MD_W'(j + 1);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        maxdig_next   = maxdig_reg;
        pass_next     = pass_reg;
        bin_k_next    = bin_k_reg;
        acc_next      = acc_reg;
        bins_next     = bins_reg;
        pend_next     = pend_reg;
        src_sel_next  = src_sel_reg;
        last_next     = last_reg;
        val_next      = val_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        tvalid_next   = tvalid_reg;
        conv_start    = 1'b0;
        ram_we        = 1'b0;
        wr_to_src     = 1'b1;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    last_next = s_tlast;
                    val_next  = s_tdata[VALUE_BITS-1:0];
                    if (count_reg < CNT_W'(MAX_ITEMS)) begin
                        conv_start = 1'b1;
                        state_next = ST_CONV;
                    end else if (s_tlast) begin
                        // batch full: drop the word, but still sort
                        state_next = ST_START;
                    end
                end
            end
            ST_CONV: begin
                if (conv_stat.done) begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[AW-1:0];
                    ram_wdata  = {conv_bcd, val_reg};
                    count_next = count_reg + CNT_W'(1);
                    if (conv_ndig > maxdig_reg) begin
                        maxdig_next = conv_ndig;
                    end
                    state_next = last_reg ? ST_START : ST_IDLE;
                end
            end
            ST_START: begin
                pass_next  = '0;
                idx_next   = '0;
                // all-zero batch: emit in arrival order
                state_next = (maxdig_reg == '0) ? ST_OUT_RD : ST_CLR;
            end
            ST_CLR: begin
                for (int b = 0; b < DRS_RADIX; b++) begin
                    bins_next[b] = '0;
                end
                idx_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_HIST;
            end
            ST_HIST: begin
                ram_raddr = idx_reg[AW-1:0];
                pend_next = (idx_reg < count_reg);
                if (idx_reg < count_reg) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    bins_next[rd_digit] = bins_reg[rd_digit] + CNT_W'(1);
                end else if (idx_reg == count_reg) begin
                    bin_k_next = '0;
                    acc_next   = '0;
                    state_next = ST_PSUM;
                end
            end
            ST_PSUM: begin
                bins_next[bin_k_reg] = psum;
                acc_next             = psum;
                if (bin_k_reg == BIN_AW'(DRS_RADIX - 1)) begin
                    idx_next   = count_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SCAT;
                end else begin
                    bin_k_next = bin_k_reg + BIN_AW'(1);
                end
            end
            ST_SCAT: begin
                // walk from last to first to keep the sort stable
                ram_raddr = AW'(idx_reg - CNT_W'(1));
                pend_next = (idx_reg != '0);
                if (idx_reg != '0) begin
                    idx_next = idx_reg - CNT_W'(1);
                end
                if (pend_reg) begin
                    ram_we              = 1'b1;
                    wr_to_src           = 1'b0;
                    ram_waddr           = AW'(bins_reg[rd_digit] - CNT_W'(1));
                    ram_wdata           = rd_entry;
                    bins_next[rd_digit] = bins_reg[rd_digit] - CNT_W'(1);
                end else if (idx_reg == '0) begin
                    src_sel_next = !src_sel_reg;
                    idx_next     = '0;
                    if (pass_reg + MD_W'(1) == maxdig_reg) begin
                        state_next = ST_OUT_RD;
                    end else begin
                        pass_next  = pass_reg + MD_W'(1);
                        state_next = ST_CLR;
                    end
                end
            end
            ST_OUT_RD: begin
                ram_raddr  = idx_reg[AW-1:0];
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                out_data_next = rd_entry[VALUE_BITS-1:0];
                out_last_next = (idx_reg + CNT_W'(1) == count_reg);
                tvalid_next   = 1'b1;
                state_next    = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (m_tready) begin
                    tvalid_next = 1'b0;
                    if (out_last_reg) begin
                        // clear batch state for the next batch
                        count_next  = '0;
                        maxdig_next = '0;
                        state_next  = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            maxdig_reg  <= '0;
            pass_reg    <= '0;
            bin_k_reg   <= '0;
            acc_reg     <= '0;
            pend_reg    <= 1'b0;
            src_sel_reg <= 1'b0;
            last_reg    <= 1'b0;
            tvalid_reg  <= 1'b0;
            for (int b = 0; b < DRS_RADIX; b++) begin
                bins_reg[b] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            maxdig_reg  <= maxdig_next;
            pass_reg    <= pass_next;
            bin_k_reg   <= bin_k_next;
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            src_sel_reg <= src_sel_next;
            last_reg    <= last_next;
            tvalid_reg  <= tvalid_next;
            bins_reg    <= bins_next;
        end
        val_reg      <= val_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = DRS_TDATA_W'(out_data_reg);
    assign m_tlast  = out_last_reg;

    `DRS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ITEMS),
        "stored word count exceeds capacity")
    `DRS_ASSERT_NOW(a_busy_not_ready, conv_stat.busy, !s_tready,
        "input ready while converter busy")
    `DRS_ASSERT_NOW(a_scatter_bin, (state_reg == ST_SCAT) && pend_reg,
        bins_reg[rd_digit] != '0, "scatter from an empty bin")
    `DRS_ASSERT_NEXT(a_batch_done, m_tvalid && m_tready && m_tlast,
        s_tready && (count_reg == '0), "batch state not cleared after final word")

endmodule

FILE: src/drs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module drs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/drs_bcd_conv.sv
// Iterative binary-to-BCD converter: one shift-and-adjust step per cycle.
module drs_bcd_conv #(
    parameter int VALUE_BITS = drs_pkg::DRS_VALUE_BITS
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         start,
    input  logic [VALUE_BITS-1:0]                        value,
    output logic [4*drs_pkg::bcd_digits(VALUE_BITS)-1:0] bcd,
    output drs_pkg::conv_stat_t                          stat
);
    import drs_pkg::*;

    localparam int DIGITS = bcd_digits(VALUE_BITS);
    localparam int BCD_W  = 4 * DIGITS;
    localparam int STEP_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  done_reg, done_next;
    logic [BCD_W-1:0]      adj;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int j = 0; j < DIGITS; j++) begin
            adj[4*j +: 4] = (bcd_reg[4*j +: 4] >= 4'd5) ? bcd_reg[4*j +: 4] + 4'd3
                                                         : bcd_reg[4*j +: 4];
        end
    end

    always_comb begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = value;
            bcd_next   = '0;
            step_next  = STEP_W'(VALUE_BITS);
        end else if (step_reg != '0) begin
            bcd_next   = {adj[BCD_W-2:0], shift_reg[VALUE_BITS-1]};
            shift_next = shift_reg << 1;
            step_next  = step_reg - STEP_W'(1);
            done_next  = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign bcd       = bcd_reg;
    assign stat.busy = (step_reg != '0);
    assign stat.done = done_reg;

endmodule
